@@ rtl/core/buddy_allocator_defines.svh @@
// Assertion macros shared by the buddy allocator RTL
`ifndef BUDDY_ALLOCATOR_DEFINES_SVH
`define BUDDY_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, quiet in reset
`define BA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
// next-cycle implication, sampled on clk_i, quiet in reset
`define BA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`else
`define BA_ASSERT_NOW(lbl, ante, cons)
`define BA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/ba_pkg.sv @@
// Shared constants, codes and helpers for the buddy allocator
`default_nettype none
package ba_pkg;

  localparam int unsigned MAX_ORDER_DEF = 10;
  localparam int unsigned SIZE_W        = 11;
  localparam int unsigned OFF_W         = 10;
  localparam int unsigned ORDER_W       = 4;
  localparam int unsigned SIZE_LVL_W    = 4;

  localparam logic [ORDER_W-1:0] HEAP_ORDER_RST = 4'd10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // ceiling of log2 of the size; zero and one map to level 0
  function automatic logic [SIZE_LVL_W-1:0] size_level(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]     m;
    logic [SIZE_LVL_W-1:0] l;
    m = size - SIZE_W'(1);
    l = '0;
    if (size > SIZE_W'(1)) begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (m[i]) begin
          l = SIZE_LVL_W'(i + 1);
        end
      end
    end
    return l;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ba_map.sv @@
// Free-bitmap store: one write port, one read port with registered data
`default_nettype none
module ba_map #(
  parameter int unsigned ROW_W  = 6,
  parameter int unsigned WORD_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              re_i,
  input  wire logic [ROW_W-1:0]  raddr_i,
  input  wire logic              we_i,
  input  wire logic [ROW_W-1:0]  waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [2**ROW_W];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/buddy_allocator.sv @@
// Binary buddy allocator: sequencer around a word-wide free-bitmap store
// Allocate scans bitmap rows, climbs a level when one is exhausted, then splits down;
//   free checks its own bit, probes buddies and merges, and rejects a double free;
//   an item rejected on its fields goes straight to the strobe. One item at a time;
//   busy holds until the strobe. Reset and heap_order writes run a clearing pass with
//   busy high; the result shows for one cycle on done_o and cannot stall.
`default_nettype none
`include "buddy_allocator_defines.svh"
module buddy_allocator import ba_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [SIZE_W-1:0]  request_size_i,
  input  wire logic [OFF_W-1:0]   block_offset_i,
  // result strobe
  output logic                    done_o,
  output logic      [OFF_W-1:0]   granted_offset_o,
  output logic                    ok_o,
  // heap_order register write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [ORDER_W-1:0] cfg_data_i
);

  // Bitmap layout: level l occupies slots 2^(MAX_ORDER-l)-1 onwards, so level
  // MAX_ORDER is slot 0 and level 0 fills the top half. Slots pack into rows.
  localparam int unsigned SLOT_W = MAX_ORDER + 1;
  localparam int unsigned BIT_W  = (SLOT_W - 1 < 5) ? SLOT_W - 1 : 5;
  localparam int unsigned WORD_W = 2 ** BIT_W;
  localparam int unsigned ROW_W  = SLOT_W - BIT_W;
  localparam int unsigned LVL_W  = ($clog2(MAX_ORDER + 1) > SIZE_LVL_W) ?
                                   $clog2(MAX_ORDER + 1) : SIZE_LVL_W;
  localparam int unsigned OA_W   = (MAX_ORDER > OFF_W) ? MAX_ORDER : OFF_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_INIT, S_SCAN_RD, S_SCAN_EV, S_SPLIT_RD, S_SPLIT_EV,
    S_FCHK_RD, S_FCHK_EV, S_MERGE_RD, S_MERGE_EV, S_SET_RD, S_SET_EV, S_DONE
  } state_e;

  state_e             state_q;
  logic [ORDER_W-1:0] order_q;
  logic               op_q;
  logic               ok_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [LVL_W-1:0]   k_q;
  logic [OA_W-1:0]    off_q;
  logic [ROW_W-1:0]   row_q;

  // first slot of a level
  function automatic logic [SLOT_W-1:0] level_base(input logic [LVL_W-1:0] l);
    return (SLOT_W'(1) << (LVL_W'(MAX_ORDER) - l)) - SLOT_W'(1);
  endfunction

  // effective heap order and the level of the incoming size
  logic [LVL_W-1:0] heap_lvl;
  logic [LVL_W-1:0] in_lvl;
  logic             free_ok;

  assign heap_lvl = (LVL_W'(order_q) > LVL_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER)
                                                          : LVL_W'(order_q);
  assign in_lvl   = LVL_W'(size_level(request_size_i));
  // free must be in range, aligned to its block size and within the heap
  assign free_ok  = (in_lvl <= heap_lvl) && ((block_offset_i >> heap_lvl) == '0) &&
                    (((block_offset_i >> in_lvl) << in_lvl) == block_offset_i);

  // single-bit target: the block under work for split, check, merge and set
  logic [LVL_W-1:0]  tgt_lvl;
  logic [SLOT_W-1:0] tgt_idx;
  logic [SLOT_W-1:0] tgt_slot;
  logic [ROW_W-1:0]  tgt_row;
  logic [BIT_W-1:0]  tgt_bit;

  always_comb begin
    tgt_lvl = k_q;
    tgt_idx = SLOT_W'(off_q >> k_q);
    case (state_q) inside
      S_SPLIT_RD, S_SPLIT_EV: begin
        // upper half one level down
        tgt_lvl = k_q - LVL_W'(1);
        tgt_idx = SLOT_W'(off_q >> (k_q - LVL_W'(1))) | SLOT_W'(1);
      end
      S_MERGE_RD, S_MERGE_EV: begin
        tgt_idx = SLOT_W'(off_q >> k_q) ^ SLOT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign tgt_slot = level_base(tgt_lvl) + tgt_idx;
  assign tgt_row  = tgt_slot[SLOT_W-1:BIT_W];
  assign tgt_bit  = tgt_slot[BIT_W-1:0];

  // level scan: find the lowest free slot of level k_q inside the heap
  logic [SLOT_W-1:0] lo_slot;
  logic [SLOT_W-1:0] hi_slot;
  logic [WORD_W-1:0] mask_lo;
  logic [WORD_W-1:0] mask_hi;
  logic [WORD_W-1:0] cand;
  logic [BIT_W-1:0]  pos;
  logic              found;
  logic [SLOT_W-1:0] found_idx;
  logic [OA_W-1:0]   found_off;
  logic [WORD_W-1:0] mem_rdata;

  assign lo_slot = level_base(k_q);
  assign hi_slot = lo_slot + (SLOT_W'(1) << (heap_lvl - k_q)) - SLOT_W'(1);
  assign mask_lo = (row_q == lo_slot[SLOT_W-1:BIT_W]) ?
                   ({WORD_W{1'b1}} << lo_slot[BIT_W-1:0]) : {WORD_W{1'b1}};
  assign mask_hi = (row_q == hi_slot[SLOT_W-1:BIT_W]) ?
                   ~(({WORD_W{1'b1}} << hi_slot[BIT_W-1:0]) << 1) : {WORD_W{1'b1}};
  assign cand    = mem_rdata & mask_lo & mask_hi;
  assign found   = |cand;

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign found_idx = {row_q, pos} - lo_slot;
  assign found_off = OA_W'(found_idx) << k_q;

  // clearing pass: only the whole-heap block is left free
  logic [SLOT_W-1:0] init_slot;
  assign init_slot = level_base(heap_lvl);

  // bitmap port control
  logic              mem_re;
  logic [ROW_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              tgt_hit;

  assign tgt_hit = mem_rdata[tgt_bit];

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = tgt_row;
    mem_we    = 1'b0;
    mem_waddr = tgt_row;
    mem_wdata = mem_rdata | (WORD_W'(1) << tgt_bit);
    case (state_q) inside
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = row_q;
        mem_wdata = (row_q == init_slot[SLOT_W-1:BIT_W]) ?
                    (WORD_W'(1) << init_slot[BIT_W-1:0]) : '0;
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = row_q;
      end
      S_SPLIT_RD, S_FCHK_RD, S_MERGE_RD, S_SET_RD: begin
        mem_re = 1'b1;
      end
      S_SCAN_EV: begin
        // take the block found
        mem_we    = found;
        mem_waddr = row_q;
        mem_wdata = mem_rdata & ~(WORD_W'(1) << pos);
      end
      S_SPLIT_EV, S_SET_EV: begin
        mem_we = 1'b1;
      end
      S_MERGE_EV: begin
        // buddy absorbed: drop its free bit
        mem_we    = tgt_hit;
        mem_wdata = mem_rdata & ~(WORD_W'(1) << tgt_bit);
      end
      default: begin
      end
    endcase
  end

  ba_map #(
    .ROW_W  (ROW_W),
    .WORD_W (WORD_W)
  ) u_map (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      order_q <= HEAP_ORDER_RST;
      op_q    <= OP_ALLOC;
      ok_q    <= 1'b0;
      lvl_q   <= '0;
      k_q     <= '0;
      off_q   <= '0;
      row_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // new heap order: rebuild the bitmap
      order_q <= cfg_data_i;
      row_q   <= '0;
      state_q <= S_CLEAR;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          row_q <= row_q + ROW_W'(1);
          if (row_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q  <= op_i;
            ok_q  <= 1'b0;
            lvl_q <= in_lvl;
            k_q   <= in_lvl;
            off_q <= OA_W'(block_offset_i);
            if (op_i == OP_ALLOC) begin
              state_q <= (in_lvl <= heap_lvl) ? S_SCAN_INIT : S_DONE;
            end else begin
              state_q <= free_ok ? S_FCHK_RD : S_DONE;
            end
          end
        end
        S_SCAN_INIT: begin
          row_q   <= lo_slot[SLOT_W-1:BIT_W];
          state_q <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (found) begin
            off_q <= found_off;
            if (k_q == lvl_q) begin
              ok_q    <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SPLIT_RD;
            end
          end else if (row_q == hi_slot[SLOT_W-1:BIT_W]) begin
            // level exhausted: climb or give up
            if (k_q == heap_lvl) begin
              state_q <= S_DONE;
            end else begin
              k_q     <= k_q + LVL_W'(1);
              state_q <= S_SCAN_INIT;
            end
          end else begin
            row_q   <= row_q + ROW_W'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_SPLIT_RD: begin
          state_q <= S_SPLIT_EV;
        end
        S_SPLIT_EV: begin
          k_q <= k_q - LVL_W'(1);
          if (k_q - LVL_W'(1) == lvl_q) begin
            ok_q    <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_SPLIT_RD;
          end
        end
        S_FCHK_RD: begin
          state_q <= S_FCHK_EV;
        end
        S_FCHK_EV: begin
          // already free: reject as a double free
          if (tgt_hit) begin
            state_q <= S_DONE;
          end else begin
            state_q <= (k_q < heap_lvl) ? S_MERGE_RD : S_SET_RD;
          end
        end
        S_MERGE_RD: begin
          state_q <= S_MERGE_EV;
        end
        S_MERGE_EV: begin
          if (tgt_hit) begin
            off_q   <= off_q & ~(OA_W'(1) << k_q);
            k_q     <= k_q + LVL_W'(1);
            state_q <= ((k_q + LVL_W'(1)) < heap_lvl) ? S_MERGE_RD : S_SET_RD;
          end else begin
            state_q <= S_SET_RD;
          end
        end
        S_SET_RD: begin
          state_q <= S_SET_EV;
        end
        S_SET_EV: begin
          ok_q    <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_q != S_IDLE);
  // hold off a register write while an item is being taken
  assign cfg_ready_o      = (state_q == S_CLEAR) || ((state_q == S_IDLE) && !start);
  assign done_o           = (state_q == S_DONE);
  assign ok_o             = ok_q;
  assign granted_offset_o = ((op_q == OP_ALLOC) && ok_q) ? off_q[OFF_W-1:0] : '0;

  // hold the strobe to a single cycle per item
  `BA_ASSERT_NEXT(a_done_single, done_o, !done_o)
  // an accepted item makes the block busy
  `BA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a failed or free result carries no offset
  `BA_ASSERT_NOW(a_fail_zero, done_o && !ok_o, granted_offset_o == '0)
  // no config write slips in while an item is under work
  `BA_ASSERT_NOW(a_cfg_idle, cfg_valid_i && cfg_ready_o, !done_o)

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the buddy allocator: directed table then random alloc/free traffic
`default_nettype none
module testbench;
  import ba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXO      = MAX_ORDER_DEF;
  localparam int unsigned MAP_BITS  = (1 << (MAXO + 1)) - 1;
  localparam int unsigned CYCLE_CAP = 1500000;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             ok;
  } grant_t;

  typedef struct {
    logic             op;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0] offs;
    logic             known;   // expected result typed in the row
    logic [OFF_W-1:0] x_off;
    logic             x_ok;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic op_i = OP_ALLOC;
  logic [SIZE_W-1:0] request_size_i = '0;
  logic [OFF_W-1:0] block_offset_i = '0;
  logic done_o;
  logic [OFF_W-1:0] granted_offset_o;
  logic ok_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ORDER_W-1:0] cfg_data_i = '0;

  buddy_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .request_size_i, .block_offset_i,
    .done_o, .granted_offset_o, .ok_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic              free_bits [MAP_BITS];
  logic [ORDER_W-1:0] order_reg;
  grant_t            grants_due[$];
  int unsigned       fail_count = 0;
  int unsigned       cycles = 0;
  int unsigned       idle_pct = 0;
  // live allocations, used to build plausible frees
  logic [OFF_W-1:0]  live_off[$];
  logic [SIZE_W-1:0] live_size[$];

  function automatic int unsigned map_slot(int unsigned lvl, int unsigned idx);
    return ((1 << (MAXO - lvl)) - 1) + idx;
  endfunction

  function automatic int unsigned heap_lvl();
    return (order_reg > MAXO) ? MAXO : order_reg;
  endfunction

  function automatic void clear_heap();
    foreach (free_bits[i]) free_bits[i] = 1'b0;
    free_bits[map_slot(heap_lvl(), 0)] = 1'b1;
  endfunction

  function automatic int unsigned round_level(logic [SIZE_W-1:0] size);
    int unsigned p, s;
    p = 1;
    s = 0;
    while (p < size) begin
      p = p << 1;
      s++;
    end
    return s;
  endfunction

  // work out the grant for one item and update the bitmap copy
  function automatic grant_t serve_request(logic op, logic [SIZE_W-1:0] size,
                                           logic [OFF_W-1:0] offs_in);
    grant_t g;
    int unsigned h, lvl, o, up, bud;
    bit found;
    h = heap_lvl();
    lvl = round_level(size);
    o = offs_in;
    g = '0;
    found = 0;
    if (op == OP_ALLOC) begin
      if (lvl <= h) begin
        for (int unsigned k = lvl; k <= h && !found; k++) begin
          for (int unsigned b = 0; b < (1 << (h - k)) && !found; b++) begin
            if (free_bits[map_slot(k, b)]) begin
              free_bits[map_slot(k, b)] = 1'b0;
              g.offset = OFF_W'(b << k);
              for (int unsigned j = k; j > lvl; j--) begin
                up = (b << k) + (1 << (j - 1));
                free_bits[map_slot(j - 1, up >> (j - 1))] = 1'b1;
              end
              found = 1;
            end
          end
        end
        g.ok = found;
      end
    end else if (lvl <= h && o < (1 << h) && (o & ((1 << lvl) - 1)) == 0 &&
                 !free_bits[map_slot(lvl, o >> lvl)]) begin
      // merge upwards while the buddy is free
      while (lvl < h) begin
        bud = o ^ (1 << lvl);
        if (!free_bits[map_slot(lvl, bud >> lvl)]) break;
        free_bits[map_slot(lvl, bud >> lvl)] = 1'b0;
        o = o & ~(1 << lvl);
        lvl++;
      end
      free_bits[map_slot(lvl, o >> lvl)] = 1'b1;
      g.ok = 1'b1;
    end
    return g;
  endfunction

  // check every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    grant_t want;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (grants_due.size() == 0) begin
        $error("result with nothing expected: offset %0d ok %0b", granted_offset_o, ok_o);
        fail_count++;
      end else begin
        want = grants_due.pop_front();
        if (granted_offset_o !== want.offset) begin
          $error("granted_offset: expected %0d, got %0d", want.offset, granted_offset_o);
          fail_count++;
        end
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // hand one item over; start stays high until the next idle gap or drain
  task automatic issue_item(logic op, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] offs,
                            logic known, logic [OFF_W-1:0] x_off, logic x_ok);
    grant_t g;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    op_i           <= op;
    request_size_i <= size;
    block_offset_i <= offs;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    g = serve_request(op, size, offs);
    if (known && (g.offset !== x_off || g.ok !== x_ok)) begin
      $error("table row disagrees with predictor: offset %0d/%0d ok %0b/%0b",
             x_off, g.offset, x_ok, g.ok);
      fail_count++;
    end
    grants_due.push_back(g);
    if (op == OP_ALLOC && g.ok) begin
      live_off.push_back(g.offset);
      live_size.push_back(size);
    end
    @(negedge clk_i);
  endtask

  // drop start, then wait out all results plus the tail of a free that merges deep
  task automatic drain_results();
    start <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] value);
    drain_results();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_reg = value;
    clear_heap();
    live_off.delete();
    live_size.delete();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_items(int unsigned count);
    int unsigned pick, h, sz, r;
    for (int unsigned n = 0; n < count; n++) begin
      h = heap_lvl();
      r = $urandom_range(99);
      if (r < 45) begin
        // allocate, mostly sizes that fit
        sz = (r < 40) ? $urandom_range((1 << h), 1) : $urandom_range(2047);
        issue_item(OP_ALLOC, SIZE_W'(sz), OFF_W'($urandom), 0, '0, 0);
      end else if (r < 85 && live_off.size() != 0) begin
        // free a block that was granted
        pick = $urandom_range(live_off.size() - 1);
        issue_item(OP_FREE, live_size[pick], live_off[pick], 0, '0, 0);
        live_off.delete(pick);
        live_size.delete(pick);
      end else begin
        // noise: random frees, misaligned, out of range, double
        issue_item(OP_FREE, SIZE_W'($urandom_range(2047) >> $urandom_range(11)),
                   OFF_W'($urandom), 0, '0, 0);
      end
    end
  endtask

  row_t plan[$];

  initial begin
    order_reg = HEAP_ORDER_RST;
    clear_heap();
    // directed table at order 10
    plan.push_back('{OP_ALLOC, 11'd1024, 10'd0,   1, 10'd0,   1}); // whole heap
    plan.push_back('{OP_ALLOC, 11'd1,    10'd0,   1, 10'd0,   0}); // nothing fits
    plan.push_back('{OP_FREE,  11'd1024, 10'd0,   1, 10'd0,   1});
    plan.push_back('{OP_FREE,  11'd1024, 10'd0,   1, 10'd0,   0}); // double free
    plan.push_back('{OP_ALLOC, 11'd2047, 10'd0,   1, 10'd0,   0}); // too large
    plan.push_back('{OP_ALLOC, 11'd0,    10'd1023,1, 10'd0,   1}); // zero size
    plan.push_back('{OP_ALLOC, 11'd1,    10'd0,   1, 10'd1,   1});
    plan.push_back('{OP_ALLOC, 11'd3,    10'd0,   1, 10'd4,   1}); // ceiling level
    plan.push_back('{OP_FREE,  11'd4,    10'd6,   1, 10'd0,   0}); // misaligned
    plan.push_back('{OP_FREE,  11'd2047, 10'd0,   1, 10'd0,   0}); // free too large
    plan.push_back('{OP_ALLOC, 11'd512,  10'd0,   0, 10'd0,   0});
    plan.push_back('{OP_FREE,  11'd1,    10'd1,   0, 10'd0,   0});
    plan.push_back('{OP_FREE,  11'd1,    10'd0,   0, 10'd0,   0});
    plan.push_back('{OP_FREE,  11'd4,    10'd4,   0, 10'd0,   0}); // merges
    plan.push_back('{OP_FREE,  11'd512,  10'd512, 0, 10'd0,   0});
    plan.push_back('{OP_ALLOC, 11'd1025, 10'd0,   0, 10'd0,   0});
    plan.push_back('{OP_FREE,  11'd1,    10'd1023,0, 10'd0,   0});

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i])
      issue_item(plan[i].op, plan[i].size, plan[i].offs, plan[i].known,
                 plan[i].x_off, plan[i].x_ok);

    // extremes of the register: smallest heap of one byte, clamped order
    write_order(4'd0);
    issue_item(OP_ALLOC, 11'd2, 10'd0, 1, 10'd0, 0);
    issue_item(OP_ALLOC, 11'd1, 10'd0, 1, 10'd0, 1);
    issue_item(OP_FREE,  11'd1, 10'd1, 1, 10'd0, 0);
    issue_item(OP_FREE,  11'd1, 10'd0, 1, 10'd0, 1);
    write_order(4'd15);
    issue_item(OP_ALLOC, 11'd1024, 10'd0, 1, 10'd0, 1);

    // random phases over several heap sizes and idling levels
    idle_pct = 0;   write_order(4'd4);  random_items(300);
    drain_results();  // sender holds off until all results are in
    idle_pct = 67;  write_order(4'd10); random_items(350);
    idle_pct = 26;  write_order(4'd6);  random_items(300);
    idle_pct = 0;   write_order(4'd2);  random_items(200);
    idle_pct = 67;  write_order(4'd8);  random_items(300);

    drain_results();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ buddy_allocator.f @@
+incdir+rtl/core
rtl/core/ba_pkg.sv
rtl/core/ba_map.sv
rtl/core/buddy_allocator.sv
tb/sv/testbench.sv
